### hw/rtl/ssa_pkg.sv
package ssa_pkg;

  localparam int SLOT_CAPACITY = 4096;
  localparam int SPAN_BYTES    = 65536;

  localparam int IDX_W  = $clog2(SLOT_CAPACITY);      // slot index
  localparam int CNT_W  = $clog2(SLOT_CAPACITY) + 1;  // counts up to SLOT_CAPACITY
  localparam int OFF_W  = $clog2(SPAN_BYTES);         // byte offset in span
  localparam int LG_W   = 4;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_SPAN     = 2'd2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

  localparam logic [LG_W-1:0] LG_MIN = 4'd4;
  localparam logic [LG_W-1:0] LG_MAX = 4'd14;

  // register reset values
  localparam logic [LG_W-1:0]  LG_RST    = 4'd4;
  localparam logic [OFF_W-1:0] FIRST_RST = 16'd592;
  localparam logic [CNT_W-1:0] SLOTS_RST = 13'd4059;
  localparam int ROOM_RST  = (SPAN_BYTES - 592) >> 4;
  localparam int COUNT_RST = (4059 < ROOM_RST) ? 4059 : ROOM_RST;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHECK,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FULL    = 2'd1,
    EV_PARTIAL = 2'd2,
    EV_EMPTY   = 2'd3
  } list_event_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  // classified request between front and back
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } req_t;

  // effective configuration seen by the back end
  typedef struct packed {
    logic [LG_W-1:0]  lg;
    logic [OFF_W-1:0] first;
    logic [CNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] number;
    logic [OFF_W-1:0] addr;
    logic [CNT_W-1:0] live;
    list_event_t      list_event;
  } res_t;

endpackage

### hw/rtl/ssa_front.sv
module ssa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          req_valid,
  input  logic [ssa_pkg::MODE_W-1:0]     req_mode,
  input  logic [ssa_pkg::OFF_W-1:0]      req_offset,
  input  logic                          q_full,
  output logic                          req_ready,
  output logic                          push,
  output ssa_pkg::req_t                 push_req,
  output ssa_pkg::cfg_t                 cfg
);
  import ssa_pkg::*;

  logic [LG_W-1:0]  lg_raw_r;
  logic [OFF_W-1:0] first_r;
  logic [CNT_W-1:0] slots_r;
  cfg_t             cfg_r;
  cfg_t             cfg_nxt;

  logic [LG_W-1:0]  lg_eff;
  logic [OFF_W:0]   room;
  logic [CNT_W-1:0] slots_cap;
  logic [OFF_W-1:0] delta;
  logic [OFF_W-1:0] shifted;
  logic [OFF_W-1:0] low_mask;
  logic             in_range;
  logic             aligned;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_raw_r <= LG_RST;
      first_r  <= FIRST_RST;
      slots_r  <= SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_SIZE_LOG2:    lg_raw_r <= cfg_wdata[LG_W-1:0];
        CFG_FIRST_SLOT_OFFSET: first_r  <= cfg_wdata[OFF_W-1:0];
        CFG_SLOTS_IN_SPAN:     slots_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lg_raw_r < LG_MIN)      lg_eff = LG_MIN;
    else if (lg_raw_r > LG_MAX) lg_eff = LG_MAX;
    else                        lg_eff = lg_raw_r;
  end

  // usable slot count: limited by SLOT_CAPACITY and by room after slot zero
  always_comb begin
    room      = ((OFF_W+1)'(SPAN_BYTES) - {1'b0, first_r}) >> lg_eff;
    slots_cap = (slots_r > CNT_W'(SLOT_CAPACITY)) ? CNT_W'(SLOT_CAPACITY) : slots_r;
    cfg_nxt.lg    = lg_eff;
    cfg_nxt.first = first_r;
    cfg_nxt.count = ({{(OFF_W+1-CNT_W){1'b0}}, slots_cap} < room) ? slots_cap
                                                                  : room[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lg    <= LG_RST;
      cfg_r.first <= FIRST_RST;
      cfg_r.count <= CNT_W'(COUNT_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // classify: decode the offset into a slot index, mark bad offsets as rejects early
  always_comb begin
    in_range = (req_offset >= first_r);
    delta    = req_offset - first_r;
    shifted  = delta >> lg_eff;
    low_mask = (OFF_W'(1) << lg_eff) - OFF_W'(1);
    aligned  = ((delta & low_mask) == '0);
    push_req.idx = shifted[IDX_W-1:0];
    unique case (req_mode)
      MODE_ALLOC: push_req.op = OP_ALLOC;
      MODE_FREE:  push_req.op = (in_range && aligned) ? OP_FREE : OP_REJECT;
      MODE_CHECK: push_req.op = (in_range && aligned) ? OP_CHECK : OP_REJECT;
      default:    push_req.op = OP_REJECT;
    endcase
  end

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

endmodule

### hw/rtl/ssa_queue.sv
module ssa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssa_pkg::req_t push_req,
  input  logic          pop,
  output ssa_pkg::req_t head,
  output logic          full,
  output logic          empty
);
  import ssa_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

### hw/rtl/ssa_back.sv
module ssa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ssa_pkg::cfg_t cfg,
  input  ssa_pkg::req_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_ready,
  output ssa_pkg::res_t res
);
  import ssa_pkg::*;

  back_state_t state_r;
  back_state_t state_nxt;
  logic        fire;

  req_t             cur_r;
  logic [IDX_W-1:0] top_r;
  logic [IDX_W-1:0] top_nxt;
  logic [CNT_W-1:0] hw_r;
  logic [CNT_W-1:0] hw_nxt;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] used_nxt;
  logic [CNT_W-1:0] depth;
  logic             hit;
  logic             got;
  logic [IDX_W-1:0] take_idx;
  logic [OFF_W-1:0] slot_off;

  logic             out_valid_r;
  res_t             out_r;
  res_t             res_nxt;

  // memories: live flags and free-list links
  logic             live_mem [SLOT_CAPACITY];
  logic [IDX_W-1:0] link_mem [SLOT_CAPACITY];
  logic             live_rd_r;
  logic [IDX_W-1:0] link_rd_r;
  logic             live_we;
  logic [IDX_W-1:0] live_wa;
  logic             live_wd;
  logic             link_we;
  logic [IDX_W-1:0] link_wa;
  logic [IDX_W-1:0] link_wd;

  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    if (pop)     live_rd_r <= live_mem[head.idx];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (pop)     link_rd_r <= link_mem[top_r];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_FETCH: if (!q_empty) state_nxt = BK_EXEC;
      BK_EXEC:  if (!out_valid_r || res_ready) state_nxt = BK_FETCH;
      default:  state_nxt = BK_FETCH;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    fire = 1'b0;
    unique case (state_r)
      BK_FETCH: pop  = !q_empty;
      BK_EXEC:  fire = !out_valid_r || res_ready;
      default: ;
    endcase
  end

  // execute one request against the stack and live flags
  always_comb begin
    hw_nxt   = hw_r;
    used_nxt = used_r;
    top_nxt  = top_r;
    got      = 1'b0;
    take_idx = cur_r.idx;
    live_wd  = 1'b0;
    link_wd  = top_r;
    live_we  = 1'b0;
    link_we  = 1'b0;
    depth    = hw_r - used_r;
    // entries at or above the high-water mark were never written: not live
    hit = ({1'b0, cur_r.idx} < cfg.count) && ({1'b0, cur_r.idx} < hw_r) && live_rd_r;
    res_nxt.status     = ST_REJECT;
    res_nxt.number     = '0;
    res_nxt.addr       = '0;
    res_nxt.list_event = EV_NONE;
    case (cur_r.op)
      OP_ALLOC: begin
        if (depth != '0) begin
          got      = 1'b1;
          take_idx = top_r;
          top_nxt  = link_rd_r;
        end else if (hw_r < cfg.count) begin
          got      = 1'b1;
          take_idx = hw_r[IDX_W-1:0];
          hw_nxt   = hw_r + CNT_W'(1);
        end
        if (got) begin
          live_we        = 1'b1;
          live_wd        = 1'b1;
          used_nxt       = used_r + CNT_W'(1);
          res_nxt.status = ST_OK;
          res_nxt.number = take_idx;
          if (hw_nxt == used_nxt && hw_nxt >= cfg.count) res_nxt.list_event = EV_FULL;
          else if (used_nxt == CNT_W'(1))                res_nxt.list_event = EV_PARTIAL;
        end else begin
          res_nxt.status = ST_NO_SLOT;
        end
      end
      OP_FREE: begin
        if (hit) begin
          live_we        = 1'b1;
          link_we        = 1'b1;
          top_nxt        = cur_r.idx;
          used_nxt       = used_r - CNT_W'(1);
          res_nxt.status = ST_OK;
          res_nxt.number = cur_r.idx;
          if (used_nxt == '0)           res_nxt.list_event = EV_EMPTY;
          else if (used_r == cfg.count) res_nxt.list_event = EV_PARTIAL;
        end
      end
      OP_CHECK: begin
        if (hit) begin
          res_nxt.status = ST_OK;
          res_nxt.number = cur_r.idx;
        end
      end
      default: ;
    endcase
    slot_off = OFF_W'({{(OFF_W-IDX_W){1'b0}}, res_nxt.number} << cfg.lg);
    if (res_nxt.status == ST_OK) res_nxt.addr = cfg.first + slot_off;
    res_nxt.live = used_nxt;
    live_we = live_we && fire;
    link_we = link_we && fire;
  end

  assign live_wa = take_idx;
  assign link_wa = cur_r.idx;

  always_ff @(posedge clk) begin
    if (pop)  cur_r <= head;
    if (fire) out_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      out_valid_r <= 1'b0;
      top_r       <= '0;
      hw_r        <= '0;
      used_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        top_r       <= top_nxt;
        hw_r        <= hw_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

### hw/rtl/span_slot_allocator_core.sv
// Slot allocator for one 64 KiB span cut into equal power-of-two slots.
// Input channel (in_*): one request per transfer. in_tuser carries the mode
// (allocate, free, check); in_tdata carries the byte offset used by free and
// check. Output channel (out_*): exactly one response per request, in order,
// with the status on out_tuser and slot number, slot address, live count and
// list event packed in out_tdata.
// Configuration (cfg_*): slot size, offset of slot zero and slot count; write
// only while no request is outstanding.
// A response passes the queue, the back-end request register and the output
// register. The back end finishes each request before it takes the next, due
// to the read-then-write pass over the live-flag and link memories.
// A two-entry queue sits between the request decoder and the back end, and
// the response sits in an output register, so requests keep flowing while a
// response waits. When the receiver stalls, the output register holds, the
// back end holds one fetched request, the queue fills and in_tready drops.
// Reset (rst_n, synchronous) restores the register defaults and empties the
// span; no memory clearing pass runs, requests are taken the next cycle.
module span_slot_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] byte_offset
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // response channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [11:0] slot_number, [27:12] slot_address,
                                  // [40:28] live_count, [42:41] list_event, zero pad
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import ssa_pkg::*;

  req_t push_req;
  req_t head;
  cfg_t cfg;
  res_t res;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // front: hold config, decode offsets, classify each request
  ssa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (in_tvalid),
    .req_mode   (in_tuser),
    .req_offset (in_tdata),
    .q_full     (q_full),
    .req_ready  (in_tready),
    .push       (push),
    .push_req   (push_req),
    .cfg        (cfg)
  );

  // decouple front and back so each stalls on its own
  ssa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: free-list pop/push, live flags, counters, response register
  ssa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the response fields, lowest field first
  assign out_tuser = res.status;
  assign out_tdata = {5'd0, res.list_event, res.live, res.addr, res.number};

endmodule
